>>> sv/rbst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rbst_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int LEN_BITS   = COORD_BITS - 1;
  localparam int EPS_BITS   = 16;
  localparam int NUM_AXES   = 3;

  // difference is one bit wider than a coordinate, magnitude of inv_dir fits coord bits
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = DIFF_BITS + COORD_BITS;
  localparam int QUOT_BITS  = PROD_BITS - FRAC_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [LEN_BITS-1:0]   len_t;
  typedef logic        [EPS_BITS-1:0]   eps_t;
  typedef logic        [PROD_BITS-1:0]  prod_t;
  typedef logic        [QUOT_BITS-1:0]  quot_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t COORD_ONE = {{(COORD_BITS-1){1'b0}}, 1'b1};
  localparam quot_t  QUOT_LIM  = {{(QUOT_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam eps_t   EPS_RESET = {{(EPS_BITS-1){1'b0}}, 1'b1};

  // product magnitude scaled down by the fraction bits (floor of the signed value),
  // then clamped to the coordinate range
  function automatic coord_t mul_sat(input prod_t p, input logic neg);
    quot_t q;
    q = {1'b0, p[PROD_BITS-1:FRAC_BITS]};
    if (neg && (p[FRAC_BITS-1:0] != '0)) begin
      q = q + quot_t'(1);
    end
    if (!neg) begin
      mul_sat = (q > QUOT_LIM) ? COORD_MAX : coord_t'(q[COORD_BITS-1:0]);
    end else begin
      mul_sat = (q > QUOT_LIM) ? COORD_MIN : -coord_t'(q[COORD_BITS-1:0]);
    end
  endfunction

  function automatic coord_t add_sat(input coord_t a, input coord_t b);
    logic signed [COORD_BITS:0] s;
    s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
    if (s[COORD_BITS] != s[COORD_BITS-1]) begin
      add_sat = s[COORD_BITS] ? COORD_MIN : COORD_MAX;
    end else begin
      add_sat = coord_t'(s[COORD_BITS-1:0]);
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/ray_box_slab_test_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Ray versus axis-aligned box slab test in signed Q16.16. One word per cycle goes in while
// out_ready allows, and one hit flag per word comes out, registered together with out_valid.
// The three registers are the input register, a register after the six distance
// multipliers (up to 33x32), and the result register. The slab narrowing (x, then y,
// then z, with early rejects and the min_exit_distance epsilon) runs in the stage after
// the products. A zero inverse direction marks an axis parallel to the ray; that axis
// gets a containment check on the origin instead. Ready propagates back through the
// stages, so up to two more words are taken while a result waits.
module ray_box_slab_test_unit
  import rbst_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  cfg_we,
  input  wire logic [EPS_BITS-1:0]   cfg_wdata,

  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [COORD_BITS-1:0] in_origin_x,
  input  wire logic signed [COORD_BITS-1:0] in_origin_y,
  input  wire logic signed [COORD_BITS-1:0] in_origin_z,
  input  wire logic signed [COORD_BITS-1:0] in_inv_dir_x,
  input  wire logic signed [COORD_BITS-1:0] in_inv_dir_y,
  input  wire logic signed [COORD_BITS-1:0] in_inv_dir_z,
  input  wire logic signed [COORD_BITS-1:0] in_box_min_x,
  input  wire logic signed [COORD_BITS-1:0] in_box_min_y,
  input  wire logic signed [COORD_BITS-1:0] in_box_min_z,
  input  wire logic [LEN_BITS-1:0]   in_box_len_x,
  input  wire logic [LEN_BITS-1:0]   in_box_len_y,
  input  wire logic [LEN_BITS-1:0]   in_box_len_z,

  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_hit
);

  eps_t eps_r;

  // stage 0: input register
  logic   s0_valid_r;
  coord_t org_r  [NUM_AXES];
  coord_t inv_r  [NUM_AXES];
  coord_t bmin_r [NUM_AXES];
  len_t   blen_r [NUM_AXES];

  // stage 1: products and flags
  logic   s1_valid_r;
  prod_t  pt_r   [NUM_AXES];
  prod_t  pe_r   [NUM_AXES];
  logic   tneg_r [NUM_AXES];
  logic   ineg_r [NUM_AXES];
  logic   par_r  [NUM_AXES];
  logic   outs_r [NUM_AXES];

  // stage 2: result
  logic   out_valid_r;
  logic   hit_r;

  logic   out_take, s1_take, s0_take;

  always_comb begin
    out_take = !out_valid_r || out_ready;
    s1_take  = !s1_valid_r || out_take;
    s0_take  = !s0_valid_r || s1_take;
  end

  assign in_ready  = s0_take;
  assign out_valid = out_valid_r;
  assign out_hit   = hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_we) begin
      eps_r <= cfg_wdata;
    end
  end

  // ---- stage 0 -> 1 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_take) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_take && in_valid) begin
      org_r[0]  <= in_origin_x;
      org_r[1]  <= in_origin_y;
      org_r[2]  <= in_origin_z;
      inv_r[0]  <= in_inv_dir_x;
      inv_r[1]  <= in_inv_dir_y;
      inv_r[2]  <= in_inv_dir_z;
      bmin_r[0] <= in_box_min_x;
      bmin_r[1] <= in_box_min_y;
      bmin_r[2] <= in_box_min_z;
      blen_r[0] <= in_box_len_x;
      blen_r[1] <= in_box_len_y;
      blen_r[2] <= in_box_len_z;
    end
  end

  logic signed [DIFF_BITS-1:0] diff   [NUM_AXES];
  logic        [DIFF_BITS-1:0] dmag   [NUM_AXES];
  logic        [COORD_BITS-1:0] imag  [NUM_AXES];
  logic                        dneg   [NUM_AXES];
  prod_t                       pt_nxt [NUM_AXES];
  prod_t                       pe_nxt [NUM_AXES];
  logic                        outs_nxt [NUM_AXES];

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      diff[k] = {bmin_r[k][COORD_BITS-1], bmin_r[k]} - {org_r[k][COORD_BITS-1], org_r[k]};
      dneg[k] = diff[k][DIFF_BITS-1];
      dmag[k] = dneg[k] ? DIFF_BITS'(-diff[k]) : DIFF_BITS'(diff[k]);
      imag[k] = inv_r[k][COORD_BITS-1] ? COORD_BITS'(-inv_r[k]) : COORD_BITS'(inv_r[k]);
      pt_nxt[k] = prod_t'(dmag[k]) * prod_t'(imag[k]);
      pe_nxt[k] = prod_t'(blen_r[k]) * prod_t'(imag[k]);
      // origin below the slab, or past its far side
      outs_nxt[k] = dneg[k] ? (dmag[k] > DIFF_BITS'(blen_r[k])) : (dmag[k] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_take) begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s0_valid_r) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        pt_r[k]   <= pt_nxt[k];
        pe_r[k]   <= pe_nxt[k];
        tneg_r[k] <= dneg[k] ^ inv_r[k][COORD_BITS-1];
        ineg_r[k] <= inv_r[k][COORD_BITS-1];
        par_r[k]  <= (inv_r[k] == '0);
        outs_r[k] <= outs_nxt[k];
      end
    end
  end

  // ---- stage 1 -> 2: slab distances and interval narrowing ----
  coord_t t_near [NUM_AXES];
  coord_t t_ext  [NUM_AXES];
  coord_t t_far  [NUM_AXES];
  coord_t tmin   [NUM_AXES];
  coord_t tmax   [NUM_AXES];
  coord_t eps_c;
  coord_t dmin, dmax;
  logic   rej;
  logic   hit_nxt;

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      t_near[k] = mul_sat(pt_r[k], tneg_r[k]);
      t_ext[k]  = mul_sat(pe_r[k], ineg_r[k]);
      t_far[k]  = add_sat(t_near[k], t_ext[k]);
      tmin[k]   = ineg_r[k] ? t_far[k] : t_near[k];
      tmax[k]   = ineg_r[k] ? t_near[k] : t_far[k];
    end
  end

  always_comb begin
    eps_c = coord_t'({{(COORD_BITS-EPS_BITS){1'b0}}, eps_r});
    rej   = 1'b0;
    if (!par_r[0]) begin
      dmin = tmin[0];
      dmax = tmax[0];
      if (dmax < eps_c || dmin > dmax) begin
        rej = 1'b1;
      end
    end else begin
      if (outs_r[0]) begin
        rej = 1'b1;
      end
      dmin = COORD_ONE;
      dmax = COORD_MAX;
    end
    // rejects are sticky, so later updates cannot revive a rejected word
    for (int k = 1; k < NUM_AXES; k++) begin
      if (par_r[k]) begin
        if (outs_r[k]) begin
          rej = 1'b1;
        end
      end else if (tmax[k] < dmax) begin
        if (tmax[k] < eps_c) begin
          rej = 1'b1;
        end
        if (tmin[k] > dmin) begin
          if (tmin[k] > tmax[k]) begin
            rej = 1'b1;
          end
          dmin = tmin[k];
        end else if (dmin > tmax[k]) begin
          rej = 1'b1;
        end
        dmax = tmax[k];
      end else if (tmin[k] > dmin) begin
        if (tmin[k] > dmax) begin
          rej = 1'b1;
        end
        dmin = tmin[k];
      end
    end
    hit_nxt = !rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && s1_valid_r) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

`default_nettype wire
